[rtl/crc8fc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc8fc_pkg
// Shared constants, types and the CRC-8 byte update for the frame checker.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

	localparam int NUM_CONNECTORS = 4;
	// four port id registers and four enable bits bound the connector count
	localparam int NUM_CONN_USED  = (NUM_CONNECTORS < 4) ? NUM_CONNECTORS : 4;

	localparam logic [7:0] MAGIC_BYTE     = 8'h5A;
	localparam logic [7:0] USB_EVENT_TYPE = 8'h01;
	localparam logic [7:0] USB_EVENT_LEN  = 8'h02;
	localparam logic [7:0] CRC_POLY       = 8'h07;

	localparam logic [7:0] STATE_OFF        = 8'h00;
	localparam logic [7:0] STATE_PERIPHERAL = 8'h01;
	localparam logic [7:0] STATE_HOST       = 8'h02;

	localparam logic [2:0] POS_MAGIC  = 3'd0;
	localparam logic [2:0] POS_TYPE   = 3'd1;
	localparam logic [2:0] POS_LENGTH = 3'd2;
	localparam logic [2:0] POS_PORT   = 3'd3;
	localparam logic [2:0] POS_STATE  = 3'd4;
	localparam logic [2:0] POS_CRC    = 3'd5;
	localparam logic [2:0] POS_IDLE   = 3'd6;

	localparam logic [2:0] REG_PORT_ID_0   = 3'd0;
	localparam logic [2:0] REG_PORT_ID_1   = 3'd1;
	localparam logic [2:0] REG_PORT_ID_2   = 3'd2;
	localparam logic [2:0] REG_PORT_ID_3   = 3'd3;
	localparam logic [2:0] REG_ENABLE_MASK = 3'd4;

	typedef enum logic [2:0] {
		STAT_APPLIED    = 3'd0,
		STAT_BAD_MAGIC  = 3'd1,
		STAT_CRC_ERR    = 3'd2,
		STAT_BAD_LENGTH = 3'd3,
		STAT_OTHER_TYPE = 3'd4,
		STAT_NO_CONN    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] magic;
		logic [7:0] ftype;
		logic [7:0] length;
		logic [7:0] port;
		logic [7:0] usb_state;
		logic [7:0] crc;
	} frame_t;

	typedef struct packed {
		status_t    status;
		logic [1:0] conn_idx;
		logic       peripheral;
		logic       host;
		logic       invalid;
	} result_t;

	// MSB-first CRC-8, no reflection, no final xor
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/crc8_frame_check_port_state_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_frame_check_port_state_unit
// Six-byte framed port-state receiver with CRC-8 (poly 0x07) check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per item with
//   frame_start marking the magic byte. Bytes outside a frame are dropped.
//   Output channel (out_valid/out_ready) carries one status item per frame,
//   loaded into the result register at the edge that accepts the crc byte,
//   so it is visible in the cycle after that byte is accepted.
//   Throughput: one byte per cycle while in_ready is high; the CRC update
//   and all checks are one byte-wide combinational step between the frame
//   registers and the result register.
//   A stalled result holds in the result register; in_ready stays high while
//   that register is empty or being drained, so only a byte arriving behind
//   an undrained result waits.
//   Reset: frame position goes idle (waiting for a start byte), output is
//   empty, port ids reset to 0,1,2,3 and the enable mask to 0.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is for the user to write only
//   while idle (unenforced); indexes past the enable mask register are ignored.
// ----------------------------------------------------------------------------
module crc8_frame_check_port_state_unit import crc8fc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_start,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      frame_status,
	output logic [1:0]      connector_index,
	output logic            peripheral_on,
	output logic            host_on,
	output logic            state_invalid
);

	logic [3:0][7:0] port_id_q;
	logic [3:0]      enable_mask_q;
	logic [2:0]      pos_q;
	frame_t          frame_q;
	result_t         result_q;
	logic            out_valid_q;

	logic            in_fire;
	logic [2:0]      pos_eff;
	logic [7:0]      crc_eff;
	logic            active;
	result_t         check_res;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign pos_eff  = frame_start ? POS_MAGIC : pos_q;
	assign crc_eff  = frame_start ? 8'h00 : frame_q.crc;
	assign active   = frame_start || (pos_q < POS_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_id_q[0]  <= 8'd0;
			port_id_q[1]  <= 8'd1;
			port_id_q[2]  <= 8'd2;
			port_id_q[3]  <= 8'd3;
			enable_mask_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PORT_ID_0:   port_id_q[0]  <= cfg_wdata;
				REG_PORT_ID_1:   port_id_q[1]  <= cfg_wdata;
				REG_PORT_ID_2:   port_id_q[2]  <= cfg_wdata;
				REG_PORT_ID_3:   port_id_q[3]  <= cfg_wdata;
				REG_ENABLE_MASK: enable_mask_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_IDLE;
			frame_q <= '0;
		end else if (in_fire && active) begin
			if (pos_eff == POS_CRC) begin
				pos_q <= POS_IDLE;
			end else begin
				pos_q       <= pos_eff + 3'd1;
				frame_q.crc <= crc8_byte(crc_eff, data_byte);
			end
			unique case (pos_eff)
				POS_MAGIC:  frame_q.magic     <= data_byte;
				POS_TYPE:   frame_q.ftype     <= data_byte;
				POS_LENGTH: frame_q.length    <= data_byte;
				POS_PORT:   frame_q.port      <= data_byte;
				POS_STATE:  frame_q.usb_state <= data_byte;
				default: ;
			endcase
		end
	end

	crc8fc_check u_check (
		.frame       (frame_q),
		.crc_byte    (data_byte),
		.port_id     (port_id_q),
		.enable_mask (enable_mask_q),
		.result      (check_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && active && pos_eff == POS_CRC) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && active && pos_eff == POS_CRC) begin
			result_q <= check_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_status    = result_q.status;
	assign connector_index = result_q.conn_idx;
	assign peripheral_on   = result_q.peripheral;
	assign host_on         = result_q.host;
	assign state_invalid   = result_q.invalid;

	// a new result only follows an accepted crc byte
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_fire && !frame_start && pos_q == POS_CRC))
		else $error("result without crc byte");

	// start byte always lands on the type position next
	a_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && frame_start |=> pos_q == POS_TYPE)
		else $error("start byte did not restart frame");

	// idle bytes leave the frame idle
	a_idle_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !frame_start && pos_q == POS_IDLE |=> pos_q == POS_IDLE)
		else $error("idle byte advanced frame");

	// fields are zero unless the update was applied
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != STAT_APPLIED |->
		(result_q.conn_idx == 2'd0 && !result_q.peripheral && !result_q.host
		 && !result_q.invalid))
		else $error("nonzero fields on rejected frame");

	// peripheral and host never both on
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.peripheral && result_q.host))
		else $error("peripheral and host both on");

endmodule
`default_nettype wire

[rtl/crc8fc_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc8fc_check
// Checks a completed frame against its crc byte and picks the connector.
// ----------------------------------------------------------------------------
module crc8fc_check import crc8fc_pkg::*; (
	input  var frame_t                  frame,
	input  wire logic [7:0]             crc_byte,
	input  wire logic [3:0][7:0]        port_id,
	input  wire logic [3:0]             enable_mask,
	output result_t                     result
);

	logic       found;
	logic [1:0] found_idx;

	// lowest enabled connector with a matching port id wins
	always_comb begin
		found     = 1'b0;
		found_idx = 2'd0;
		for (int i = NUM_CONN_USED - 1; i >= 0; i--) begin
			if (enable_mask[i] && (port_id[i] == frame.port)) begin
				found     = 1'b1;
				found_idx = 2'(i);
			end
		end
	end

	always_comb begin
		result = '0;
		priority if (frame.magic != MAGIC_BYTE) begin
			result.status = STAT_BAD_MAGIC;
		end else if (frame.crc != crc_byte) begin
			result.status = STAT_CRC_ERR;
		end else if (frame.ftype == USB_EVENT_TYPE && frame.length != USB_EVENT_LEN) begin
			result.status = STAT_BAD_LENGTH;
		end else if (frame.ftype != USB_EVENT_TYPE) begin
			result.status = STAT_OTHER_TYPE;
		end else if (!found) begin
			result.status = STAT_NO_CONN;
		end else begin
			result.status     = STAT_APPLIED;
			result.conn_idx   = found_idx;
			result.peripheral = (frame.usb_state == STATE_PERIPHERAL);
			result.host       = (frame.usb_state == STATE_HOST);
			result.invalid    = (frame.usb_state > STATE_HOST);
		end
	end

endmodule
`default_nettype wire
